[design/kmd_pkg.sv]
package kmd_pkg;

  localparam int EVENT_DEPTH   = 8;
  localparam int MAX_COLUMNS   = 4;
  localparam int MAX_ROWS      = 4;
  localparam int KEY_COUNT     = MAX_ROWS * MAX_COLUMNS;
  localparam int KEY_W         = $clog2(KEY_COUNT);
  localparam int PTR_W         = $clog2(EVENT_DEPTH);
  localparam int COL_IDX_W     = $clog2(MAX_COLUMNS);
  localparam int ROW_IDX_W     = 2;
  localparam int LEVELS_W      = 4;
  localparam int CNT_W         = 6;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [7:0] PERIODS_RESET = 8'd5;
  localparam logic [2:0] COLUMNS_RESET = 3'd4;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_FETCH  = 2'd1,
    OP_CLEAR  = 2'd2
  } opcode_t;

  typedef enum logic {
    REG_PERIODS = 1'b0,
    REG_COLUMNS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic       spare;
    logic       down;
    logic [2:0] row;
    logic [2:0] column;
  } event_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_cmd_t;

endpackage

[design/kmd_ring.sv]
module kmd_ring
  import kmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  ring_cmd_t cmd,
  input  event_t    push_data,
  output logic      empty,
  output event_t    rdata
);

  event_t ring [EVENT_DEPTH];
  logic [PTR_W-1:0] rptr;
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr_next;
  logic [PTR_W-1:0] wptr_next;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(EVENT_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign empty     = (rptr == wptr);
  assign rptr_next = ring_next(rptr);
  assign wptr_next = ring_next(wptr);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      ring[wptr] <= push_data;
    end
    if (cmd.pop) begin
      rdata <= ring[rptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr <= '0;
      wptr <= '0;
    end else if (cmd.clear) begin
      rptr <= '0;
      wptr <= '0;
    end else if (cmd.push) begin
      wptr <= wptr_next;
      if (wptr_next == rptr) begin
        rptr <= rptr_next;
      end
    end else if (cmd.pop) begin
      rptr <= rptr_next;
    end
  end

endmodule

[design/key_matrix_debounce_event_fifo.sv]
// Key matrix debouncer with an 8-entry event ring.
// Input stream (s_*): one item per transfer; opcode selects a row sample, an
// event fetch or a ring clear. Only a fetch yields a result on the output
// stream (m_*): event_valid low with all other fields zero means no event.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 periods,
// 1 columns in use); write only while the block is idle.
// Issue: a row sample stays in the issue stage while it issues each column in
// use in turn (up to 4; with no column in use it issues nothing), fetch and
// clear issue once each; unless the output stalls, the next item is taken as the
// current one issues its last column. Key status lives in a 16-entry
// memory read in the issue stage, ahead of the update stage, with the last write
// forwarded so consecutive samples of one row run back to back.
// A fetch result passes the issue and update stages and the pending register.
// Reset: key status reads as zero until written, pointers and config reset,
// no clearing pass is needed.
// Stall: the output register holds its result; one more fetch result may
// wait behind it, after which the input side stops taking items.
module key_matrix_debounce_event_fifo
  import kmd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // opcode[1:0], row_index[3:2], column_levels[7:4]
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // event_valid[0], event_down[1], event_row[4:2],
                                // event_column[7:5]
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] req_periods;
  logic [2:0] cols_cfg;
  logic [2:0] cols_sat;

  logic                 a_valid;
  opcode_t              a_op;
  logic [ROW_IDX_W-1:0] a_row;
  logic [LEVELS_W-1:0]  a_levels;
  logic [2:0]           a_cols;
  logic [COL_IDX_W-1:0] a_col;
  logic                 a_last;
  logic                 a_issue;
  logic [4:0]           key_wide;
  logic                 key_ok;
  logic [KEY_W-1:0]     a_key;
  logic                 accept;

  logic                 b_valid;
  opcode_t              b_op;
  logic [KEY_W-1:0]     b_key;
  logic [ROW_IDX_W-1:0] b_row;
  logic [COL_IDX_W-1:0] b_col;
  logic                 b_pressed;
  logic                 b_update;

  logic [7:0]           key_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] key_valid;
  logic [7:0]           kdata;
  logic                 kdata_valid;
  logic                 fwd_valid;
  logic [KEY_W-1:0]     fwd_key;
  logic [7:0]           fwd_data;

  logic [7:0]           st_cur;
  logic [7:0]           st_new;
  logic                 flip;
  logic [CNT_W-1:0]     cnt_inc;

  ring_cmd_t            ring_cmd;
  event_t               push_data;
  event_t               ring_rdata;
  logic                 ring_empty;

  logic                 pend_valid;
  logic                 pend_hit;
  logic                 move;
  logic                 stall;
  logic                 obuf_valid;
  logic [7:0]           obuf;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_periods <= PERIODS_RESET;
      cols_cfg    <= COLUMNS_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_PERIODS: req_periods <= cfg_data;
        REG_COLUMNS: cols_cfg    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign cols_sat = (cols_cfg > 3'(MAX_COLUMNS)) ? 3'(MAX_COLUMNS) : cols_cfg;

  // issue stage
  assign move     = pend_valid && (!obuf_valid || m_tready);
  assign stall    = pend_valid && !move;
  assign a_last   = (a_op != OP_SAMPLE) || ((3'(a_col) + 3'd1) >= a_cols);
  assign key_wide = 5'(a_row) * 5'(a_cols) + 5'(a_col);
  assign key_ok   = key_wide < 5'(KEY_COUNT);
  assign a_key    = key_wide[KEY_W-1:0];
  assign a_issue  = a_valid &&
                    (a_op == OP_FETCH || a_op == OP_CLEAR ||
                     (a_op == OP_SAMPLE && a_cols != 3'd0 && key_ok &&
                      4'(a_row) < 4'(MAX_ROWS)));
  assign s_tready = !stall && (!a_valid || a_last);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!stall) begin
      if (accept) begin
        a_valid <= 1'b1;
      end else if (a_valid && a_last) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      if (accept) begin
        a_op     <= opcode_t'(s_tdata[1:0]);
        a_row    <= s_tdata[3:2];
        a_levels <= s_tdata[7:4];
        a_cols   <= cols_sat;
        a_col    <= '0;
      end else if (a_valid && !a_last) begin
        a_col <= a_col + COL_IDX_W'(1);
      end
    end
  end

  // key status read, registered ahead of the update stage
  always_ff @(posedge clk) begin
    if (!stall) begin
      kdata       <= key_mem[a_key];
      kdata_valid <= key_valid[a_key];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (!stall) begin
      b_valid <= a_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      b_op      <= a_op;
      b_key     <= a_key;
      b_row     <= a_row;
      b_col     <= a_col;
      b_pressed <= !a_levels[a_col];
    end
  end

  // update stage
  assign b_update = b_valid && (b_op == OP_SAMPLE);
  assign st_cur   = (fwd_valid && fwd_key == b_key) ? fwd_data :
                    (kdata_valid ? kdata : 8'd0);
  assign cnt_inc  = (st_cur[CNT_W-1:0] < CNT_MAX) ?
                    st_cur[CNT_W-1:0] + CNT_W'(1) : st_cur[CNT_W-1:0];

  always_comb begin
    flip   = 1'b0;
    st_new = {st_cur[7], b_pressed, {CNT_W{1'b0}}};
    if (st_cur[6] == b_pressed) begin
      if ({2'b00, cnt_inc} >= req_periods && st_cur[7] != b_pressed) begin
        flip   = 1'b1;
        st_new = {b_pressed, b_pressed, {CNT_W{1'b0}}};
      end else begin
        st_new = {st_cur[7], b_pressed, cnt_inc};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && b_update) begin
      key_mem[b_key] <= st_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= '0;
      fwd_valid <= 1'b0;
    end else if (!stall) begin
      fwd_valid <= b_update;
      if (b_update) begin
        key_valid[b_key] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      fwd_key  <= b_key;
      fwd_data <= st_new;
    end
  end

  assign push_data = '{spare: 1'b0, down: b_pressed, row: 3'(b_row), column: 3'(b_col)};

  always_comb begin
    ring_cmd       = '0;
    ring_cmd.push  = !stall && b_update && flip;
    ring_cmd.pop   = !stall && b_valid && (b_op == OP_FETCH) && !ring_empty;
    ring_cmd.clear = !stall && b_valid && (b_op == OP_CLEAR);
  end

  kmd_ring u_ring (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ring_cmd),
    .push_data (push_data),
    .empty     (ring_empty),
    .rdata     (ring_rdata)
  );

  // pending fetch result and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (!stall) begin
      pend_valid <= b_valid && (b_op == OP_FETCH);
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      pend_hit <= !ring_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_valid <= 1'b0;
    end else if (move) begin
      obuf_valid <= 1'b1;
    end else if (m_tready) begin
      obuf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      obuf <= pend_hit ?
              {ring_rdata.column, ring_rdata.row, ring_rdata.down, 1'b1} : 8'd0;
    end
  end

  assign m_tvalid = obuf_valid;
  assign m_tdata  = obuf;

  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> pend_valid)
    else $error("pending fetch result lost during stall");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[7:1] == 7'd0)
    else $error("empty fetch carries non-zero fields");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    a_valid && a_op == OP_SAMPLE && a_cols != 3'd0 |-> 3'(a_col) < a_cols)
    else $error("column counter beyond columns in use");

  a_one_ring_op: assert property (@(posedge clk) disable iff (rst)
    $countones({ring_cmd.push, ring_cmd.pop, ring_cmd.clear}) <= 1)
    else $error("more than one ring operation in a cycle");

endmodule
